// File: hdl/dxc_pkg.sv
// Package for the disk extent coalescer.
// Holds field widths, opcode and step codes and the plan word passed from front to back.
// No dependencies.
`default_nettype none

package dxc_pkg;

  // Field widths, fixed by the interface
  localparam int unsigned ADDR_W = 48;
  localparam int unsigned LEN_W  = 32;
  localparam int unsigned OFF_W  = 9;
  localparam int unsigned END_W  = 10;

  // Plan queue depth between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // Input opcodes
  typedef enum logic {
    OP_READ  = 1'b0,
    OP_FLUSH = 1'b1
  } dxc_op_e;

  // Extent kinds, in emission order; also bit positions in the step mask
  typedef enum logic [1:0] {
    STEP_RUN   = 2'd0,
    STEP_LEAD  = 2'd1,
    STEP_WHOLE = 2'd2,
    STEP_TRAIL = 2'd3
  } dxc_step_e;

  localparam int unsigned NUM_STEPS = 4;

  // One classified item: which extents to emit and what they carry
  typedef struct packed {
    logic [NUM_STEPS-1:0] steps;
    logic [ADDR_W-1:0]    run_start;
    logic [LEN_W-1:0]     run_count;
    logic [ADDR_W-1:0]    sector;
    logic [OFF_W-1:0]     lead_start;
    logic [END_W-1:0]     lead_end;
    logic [LEN_W-1:0]     whole;
    logic [END_W-1:0]     trail_end;
  } dxc_plan_t;

endpackage

`default_nettype wire

// File: hdl/dxc_front.sv
// Front end of the disk extent coalescer: accepts items, tracks the pending run
// and turns each item into a plan word. Depends on dxc_pkg.
`default_nettype none

module dxc_front import dxc_pkg::*; #(
  parameter int unsigned SECTOR_BITS = 9
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              opcode_i,
  input  wire logic [ADDR_W-1:0] sector_i,
  input  wire logic [OFF_W-1:0]  byte_offset_i,
  input  wire logic [LEN_W-1:0]  byte_length_i,
  output logic                   push_valid_o,
  input  wire logic              push_ready_i,
  output dxc_plan_t              push_plan_o
);

  localparam int unsigned ROOM_W = SECTOR_BITS + 1;
  localparam logic [LEN_W-1:0]  SSIZE_L = LEN_W'(1) << SECTOR_BITS;
  localparam logic [LEN_W-1:0]  SMASK   = SSIZE_L - LEN_W'(1);
  localparam logic [ROOM_W-1:0] SSIZE_R = ROOM_W'(1) << SECTOR_BITS;

  logic [ADDR_W-1:0] run_start_q, run_start_d;
  logic [LEN_W-1:0]  run_count_q, run_count_d;

  logic              accept;
  logic              pend;
  logic              is_flush;
  logic              off_nz;
  logic              cont;
  logic              go;
  logic              new_run;
  logic [ADDR_W-1:0] run_end;
  logic [LEN_W-1:0]  whole_in;
  logic [LEN_W-1:0]  len1;
  logic [LEN_W-1:0]  len2;
  logic [LEN_W-1:0]  room_l;
  logic [LEN_W-1:0]  tail;
  logic [LEN_W-1:0]  whole2;
  logic [ROOM_W-1:0] room;
  logic [ROOM_W-1:0] lead_len;
  logic [ROOM_W-1:0] lead_sum;

  assign accept       = in_valid_i && in_ready_o;
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = accept && (push_plan_o.steps != '0);
  assign run_end      = run_start_q + ADDR_W'(run_count_q);

  // Classify the item and build its plan
  always_comb begin
    pend     = run_count_q != '0;
    is_flush = opcode_i == OP_FLUSH;
    off_nz   = byte_offset_i != '0;
    whole_in = byte_length_i >> SECTOR_BITS;

    // continue the pending run exactly
    cont = !is_flush && pend && (run_end == sector_i) && !off_nz &&
           (byte_length_i >= SSIZE_L);
    len1 = cont ? (byte_length_i & SMASK) : byte_length_i;
    go   = !pend || (len1 != '0);

    // leading partial sector
    room     = SSIZE_R - ROOM_W'(byte_offset_i);
    room_l   = LEN_W'(room);
    lead_len = (len1 < room_l) ? len1[ROOM_W-1:0] : room;
    lead_sum = ROOM_W'(byte_offset_i) + lead_len;
    if (off_nz) begin
      len2 = (len1 > room_l) ? (len1 - room_l) : '0;
    end else begin
      len2 = len1;
    end
    tail   = len2 & SMASK;
    whole2 = len2 >> SECTOR_BITS;

    push_plan_o            = '0;
    push_plan_o.run_start  = run_start_q;
    push_plan_o.run_count  = cont ? (run_count_q + whole_in) : run_count_q;
    push_plan_o.sector     = cont ? (sector_i + ADDR_W'(whole_in)) : sector_i;
    push_plan_o.lead_start = byte_offset_i;
    push_plan_o.lead_end   = END_W'(lead_sum);
    push_plan_o.whole      = whole2;
    push_plan_o.trail_end  = END_W'(tail);

    new_run = 1'b0;
    if (is_flush) begin
      push_plan_o.steps[STEP_RUN] = pend;
    end else begin
      push_plan_o.steps[STEP_RUN]   = pend && (len1 != '0);
      push_plan_o.steps[STEP_LEAD]  = go && off_nz;
      push_plan_o.steps[STEP_WHOLE] = go && (tail != '0) && (whole2 != '0);
      push_plan_o.steps[STEP_TRAIL] = go && (tail != '0);
      new_run = go && (len2 != '0) && (tail == '0);
    end
  end

  // Advance the pending run
  always_comb begin
    run_start_d = run_start_q;
    run_count_d = run_count_q;
    if (accept) begin
      if (is_flush) begin
        run_count_d = '0;
      end else if (new_run) begin
        run_start_d = sector_i + ADDR_W'(off_nz);
        run_count_d = whole2;
      end else if (push_plan_o.steps[STEP_RUN]) begin
        run_count_d = '0;
      end else if (cont) begin
        run_count_d = run_count_q + whole_in;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_start_q <= '0;
      run_count_q <= '0;
    end else begin
      run_start_q <= run_start_d;
      run_count_q <= run_count_d;
    end
  end

  // A flush always leaves no run pending
  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_flush) |=> (run_count_q == '0))
    else $error("pending run survived a flush");

  // Without a pending run no run extent is planned
  a_no_phantom_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (run_count_q == '0)) |-> !push_plan_o.steps[STEP_RUN])
    else $error("run extent planned with no run pending");

endmodule

`default_nettype wire

// File: hdl/dxc_fifo.sv
// Short plan queue between front and back of the disk extent coalescer.
// Register storage, one push and one pop port. Depends on dxc_pkg.
`default_nettype none

module dxc_fifo import dxc_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_valid_i,
  output logic           push_ready_o,
  input  wire dxc_plan_t push_plan_i,
  output logic           pop_valid_o,
  input  wire logic      pop_ready_i,
  output dxc_plan_t      pop_plan_o
);

  localparam logic [QPTR_W:0]   FULL_CNT = (QPTR_W+1)'(QUEUE_DEPTH);
  localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);

  dxc_plan_t         mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;
  logic              push;
  logic              pop;

  assign push_ready_o = count_q != FULL_CNT;
  assign pop_valid_o  = count_q != '0;
  assign pop_plan_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_plan_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("plan queue overfilled");

endmodule

`default_nettype wire

// File: hdl/dxc_back.sv
// Back end of the disk extent coalescer: walks each plan word and emits one
// extent per unstalled cycle via an output register. Depends on dxc_pkg.
`default_nettype none

module dxc_back import dxc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [ADDR_W-1:0] cfg_wdata_i,
  input  wire logic              plan_valid_i,
  output logic                   plan_ready_o,
  input  wire dxc_plan_t         plan_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [ADDR_W-1:0]      rel_sector_o,
  output logic [LEN_W-1:0]       sector_count_o,
  output logic [OFF_W-1:0]       range_start_o,
  output logic [END_W-1:0]       range_end_o,
  output logic                   last_o
);

  logic [ADDR_W-1:0]    part_q;
  logic                 busy_q, busy_d;
  logic [NUM_STEPS-1:0] steps_q, steps_d;
  dxc_plan_t            work_q;
  logic [ADDR_W-1:0]    cursor_q;
  logic [ADDR_W-1:0]    cursor_inc;
  logic                 out_valid_q, out_valid_d;
  logic [ADDR_W-1:0]    rel_q;
  logic [LEN_W-1:0]     cnt_q;
  logic [OFF_W-1:0]     rs_q;
  logic [END_W-1:0]     re_q;
  logic                 last_q;

  logic                 out_free;
  logic                 fire;
  logic                 finish;
  logic                 load;
  dxc_step_e            step;
  logic [NUM_STEPS-1:0] steps_left;
  logic [ADDR_W-1:0]    ext_sector;
  logic [LEN_W-1:0]     ext_count;
  logic [OFF_W-1:0]     ext_rs;
  logic [END_W-1:0]     ext_re;

  assign out_free     = !out_valid_q || out_ready_i;
  assign fire         = busy_q && out_free;
  assign steps_left   = steps_q & ~(NUM_STEPS'(1) << step);
  assign finish       = fire && (steps_left == '0);
  assign plan_ready_o = !busy_q || finish;
  assign load         = plan_valid_i && plan_ready_o;

  // Pick the earliest outstanding extent
  always_comb begin
    if (steps_q[STEP_RUN]) begin
      step = STEP_RUN;
    end else if (steps_q[STEP_LEAD]) begin
      step = STEP_LEAD;
    end else if (steps_q[STEP_WHOLE]) begin
      step = STEP_WHOLE;
    end else begin
      step = STEP_TRAIL;
    end
  end

  // Decode the extent fields for the chosen step
  always_comb begin
    ext_sector = cursor_q;
    ext_count  = '0;
    ext_rs     = '0;
    ext_re     = '0;
    cursor_inc = '0;
    unique case (step)
      STEP_RUN: begin
        ext_sector = work_q.run_start;
        ext_count  = work_q.run_count;
      end
      STEP_LEAD: begin
        ext_rs     = work_q.lead_start;
        ext_re     = work_q.lead_end;
        cursor_inc = ADDR_W'(1);
      end
      STEP_WHOLE: begin
        ext_count  = work_q.whole;
        cursor_inc = ADDR_W'(work_q.whole);
      end
      STEP_TRAIL: begin
        ext_re     = work_q.trail_end;
      end
      default: begin
        ext_sector = cursor_q;
      end
    endcase
  end

  // Control next state
  always_comb begin
    busy_d      = busy_q;
    steps_d     = steps_q;
    out_valid_d = out_valid_q;
    if (load) begin
      busy_d  = 1'b1;
      steps_d = plan_i.steps;
    end else if (fire) begin
      busy_d  = !finish;
      steps_d = steps_left;
    end
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      steps_q     <= '0;
      out_valid_q <= 1'b0;
      part_q      <= '0;
    end else begin
      busy_q      <= busy_d;
      steps_q     <= steps_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        part_q <= cfg_wdata_i;
      end
    end
  end

  // Hold the plan, advance the sector cursor, load the output word
  always_ff @(posedge clk_i) begin
    if (load) begin
      work_q   <= plan_i;
      cursor_q <= plan_i.sector;
    end else if (fire) begin
      cursor_q <= cursor_q + cursor_inc;
    end
    if (fire) begin
      rel_q  <= ext_sector - part_q;
      cnt_q  <= ext_count;
      rs_q   <= ext_rs;
      re_q   <= ext_re;
      last_q <= steps_left == '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign rel_sector_o   = rel_q;
  assign sector_count_o = cnt_q;
  assign range_start_o  = rs_q;
  assign range_end_o    = re_q;
  assign last_o         = last_q;

  a_busy_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (steps_q != '0))
    else $error("back end busy with no extent left");

  a_lead_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (step == STEP_LEAD) && !load) |=>
      (cursor_q == $past(cursor_q) + ADDR_W'(1)))
    else $error("cursor did not step past the leading partial sector");

endmodule

`default_nettype wire

// File: hdl/disk_extent_coalescer_unit.sv
// Disk extent coalescer, top level: front end, plan queue and back end.
// Depends on dxc_pkg, dxc_front, dxc_fifo and dxc_back.
//
// Takes read pieces (sector, byte offset, byte length) and flush words, and
// produces sector extents relative to partition_start. Contiguous pieces of
// whole sectors are merged into one pending run, which is emitted when a piece
// breaks it or on a flush. The front end takes one input word every cycle while
// the two-entry plan queue has room, and classifies it in that same cycle. The
// back end emits one extent per cycle while its output is not stalled, 0 to 4
// per item, and loads the next plan word with the last extent of the current
// one. An input word reaches the output via the plan queue, the back end's plan
// register and the output register. The output word is registered, so while a
// result waits the input side keeps accepting words until the plan queue is
// full. No clearing pass runs after reset. partition_start is to be written
// through cfg_we_i only while the block is idle; the block does not enforce it.
`default_nettype none

module disk_extent_coalescer_unit import dxc_pkg::*; #(
  parameter int unsigned SECTOR_BITS = 9
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [ADDR_W-1:0] cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              opcode_i,
  input  wire logic [ADDR_W-1:0] sector_i,
  input  wire logic [OFF_W-1:0]  byte_offset_i,
  input  wire logic [LEN_W-1:0]  byte_length_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [ADDR_W-1:0]      rel_sector_o,
  output logic [LEN_W-1:0]       sector_count_o,
  output logic [OFF_W-1:0]       range_start_o,
  output logic [END_W-1:0]       range_end_o,
  output logic                   last_o
);

  logic      push_valid;
  logic      push_ready;
  dxc_plan_t push_plan;
  logic      pop_valid;
  logic      pop_ready;
  dxc_plan_t pop_plan;

  // Classify items
  dxc_front #(
    .SECTOR_BITS (SECTOR_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .sector_i      (sector_i),
    .byte_offset_i (byte_offset_i),
    .byte_length_i (byte_length_i),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_plan_o   (push_plan)
  );

  // Buffer plans
  dxc_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_plan_i  (push_plan),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_plan_o   (pop_plan)
  );

  // Emit extents
  dxc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .plan_valid_i   (pop_valid),
    .plan_ready_o   (pop_ready),
    .plan_i         (pop_plan),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .rel_sector_o   (rel_sector_o),
    .sector_count_o (sector_count_o),
    .range_start_o  (range_start_o),
    .range_end_o    (range_end_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire

// File: verif/extent_check_pkg.sv
// Scoreboard for the disk extent coalescer testbench: extent word type and
// a class that predicts extents from accepted input words and checks results.
// Depends on dxc_pkg for field widths and opcodes.
`timescale 1ns / 1ps

package extent_check_pkg;
  import dxc_pkg::*;

  // One result word, packed in port order
  typedef struct packed {
    logic [ADDR_W-1:0] rel_sector;
    logic [LEN_W-1:0]  sector_count;
    logic [OFF_W-1:0]  range_start;
    logic [END_W-1:0]  range_end;
    logic              last;
  } extent_t;

  class extent_scoreboard;
    int unsigned       sector_bits;
    logic [ADDR_W-1:0] partition_base;
    logic [ADDR_W-1:0] run_start;
    logic [LEN_W-1:0]  run_count;
    extent_t           awaited[$];
    int unsigned       mismatches;

    function new(int unsigned sector_bits_i);
      sector_bits    = sector_bits_i;
      partition_base = '0;
      run_start      = '0;
      run_count      = '0;
      mismatches     = 0;
    endfunction

    function void set_partition(logic [ADDR_W-1:0] value);
      partition_base = value;
    endfunction

    // Queue one extent, reported relative to the partition start
    function void push_extent(logic [ADDR_W-1:0] sec, logic [LEN_W-1:0] cnt,
                              logic [LEN_W-1:0] rs, logic [LEN_W-1:0] re);
      extent_t e;
      e.rel_sector   = sec - partition_base;
      e.sector_count = cnt;
      e.range_start  = rs[OFF_W-1:0];
      e.range_end    = re[END_W-1:0];
      e.last         = 1'b0;
      awaited.push_back(e);
    endfunction

    // Work out the extents that one accepted input word causes
    function void note_input(dxc_op_e op, logic [ADDR_W-1:0] sec,
                             logic [OFF_W-1:0] off, logic [LEN_W-1:0] len);
      logic [LEN_W-1:0]  ssize, smask, whole, room, piece, left;
      logic [ADDR_W-1:0] at;
      bit                going;
      int unsigned       first;
      extent_t           tail;
      ssize = LEN_W'(1) << sector_bits;
      smask = ssize - 1;
      at    = sec;
      left  = len;
      going = 1'b1;
      first = awaited.size();
      if (op == OP_FLUSH) begin
        if (run_count != 0) push_extent(run_start, run_count, '0, '0);
        run_count = '0;
      end else begin
        if (run_count != 0) begin
          // grow the pending run when the word continues it with whole sectors
          if (((run_start + run_count) == at) && (off == 0) && (left >= ssize)) begin
            whole     = left >> sector_bits;
            run_count = run_count + whole;
            at        = at + ADDR_W'(whole);
            left      = left & smask;
          end
          if (left == 0) begin
            going = 1'b0;
          end else begin
            push_extent(run_start, run_count, '0, '0);
            run_count = '0;
          end
        end
        // leading partial sector, clipped to the room left in it
        if (going && (off != 0)) begin
          room  = ssize - LEN_W'(off);
          piece = (left < room) ? left : room;
          push_extent(at, '0, LEN_W'(off), LEN_W'(off) + piece);
          left  = left - piece;
          at    = at + 1;
        end
        if (going && (left != 0)) begin
          if ((left & smask) != 0) begin
            whole = left >> sector_bits;
            if (whole != 0) begin
              push_extent(at, whole, '0, '0);
              at = at + ADDR_W'(whole);
            end
            push_extent(at, '0, '0, left & smask);
          end else begin
            // whole sectors only: hold them as the new pending run
            run_start = at;
            run_count = left >> sector_bits;
          end
        end
      end
      // flag the final extent of this word
      if (awaited.size() > first) begin
        tail      = awaited.pop_back();
        tail.last = 1'b1;
        awaited.push_back(tail);
      end
    endfunction

    // Compare one accepted result word with the oldest prediction
    function void check_result(extent_t got);
      extent_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected extent: sector=%h count=%h range=%0d..%0d last=%b",
                   got.rel_sector, got.sector_count, got.range_start,
                   got.range_end, got.last);
      end else begin
        want = awaited.pop_front();
        if ((got.rel_sector !== want.rel_sector) ||
            (got.sector_count !== want.sector_count) ||
            (got.range_start !== want.range_start) ||
            (got.range_end !== want.range_end) ||
            (got.last !== want.last)) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("extent mismatch: want sector=%h count=%h range=%0d..%0d last=%b",
                     want.rel_sector, want.sector_count, want.range_start,
                     want.range_end, want.last);
            $display("                 got  sector=%h count=%h range=%0d..%0d last=%b",
                     got.rel_sector, got.sector_count, got.range_start,
                     got.range_end, got.last);
          end
        end
      end
    endfunction
  endclass

endpackage

// File: verif/disk_extent_coalescer_unit_tb.sv
// Testbench top for disk_extent_coalescer_unit: directed and random read and
// flush words with random idling on both sides, checked by extent_check_pkg.
// Depends on dxc_pkg, extent_check_pkg and the block's RTL.
`timescale 1ns / 1ps

module disk_extent_coalescer_unit_tb;
  import dxc_pkg::*;
  import extent_check_pkg::*;

  localparam int unsigned SECTOR_BITS   = 9;
  localparam int unsigned SECTOR_BYTES  = 1 << SECTOR_BITS;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned PHASE_WORDS   = 100;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              cfg_we_i       = 1'b0;
  logic [ADDR_W-1:0] cfg_wdata_i    = '0;
  logic              in_valid_i     = 1'b0;
  logic              in_ready_o;
  logic              opcode_i       = 1'b0;
  logic [ADDR_W-1:0] sector_i       = '0;
  logic [OFF_W-1:0]  byte_offset_i  = '0;
  logic [LEN_W-1:0]  byte_length_i  = '0;
  logic              out_valid_o;
  logic              out_ready_i    = 1'b0;
  logic [ADDR_W-1:0] rel_sector_o;
  logic [LEN_W-1:0]  sector_count_o;
  logic [OFF_W-1:0]  range_start_o;
  logic [END_W-1:0]  range_end_o;
  logic              last_o;

  extent_scoreboard  extents;
  int unsigned       cycle_count = 0;
  int unsigned       ready_left  = 0;
  int unsigned       ready_pick;
  bit                ready_level = 1'b0;
  bit                tight       = 1'b0;

  disk_extent_coalescer_unit #(.SECTOR_BITS(SECTOR_BITS)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .sector_i       (sector_i),
    .byte_offset_i  (byte_offset_i),
    .byte_length_i  (byte_length_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .rel_sector_o   (rel_sector_o),
    .sector_count_o (sector_count_o),
    .range_start_o  (range_start_o),
    .range_end_o    (range_end_o),
    .last_o         (last_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Stall the result side in stretches: short and long, between short and long free runs
  always @(posedge clk_i) begin
    if (ready_left == 0) begin
      ready_pick = $urandom_range(0, 99);
      if (ready_pick < 45) begin
        ready_level = 1'b1;
        ready_left  = $urandom_range(1, 4);
      end else if (ready_pick < 75) begin
        ready_level = 1'b0;
        ready_left  = $urandom_range(1, 3);
      end else if (ready_pick < 92) begin
        ready_level = 1'b1;
        ready_left  = $urandom_range(20, 60);
      end else begin
        ready_level = 1'b0;
        ready_left  = $urandom_range(10, 40);
      end
    end
    ready_left  = ready_left - 1;
    out_ready_i <= ready_level;
  end

  // Check every accepted result word
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      extents.check_result({rel_sector_o, sector_count_o, range_start_o,
                            range_end_o, last_o});
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [ADDR_W-1:0] rand_sector();
    case ($urandom_range(0, 3))
      0:       rand_sector = ADDR_W'($urandom_range(0, 4096));
      1:       rand_sector = {ADDR_W{1'b1}} - ADDR_W'($urandom_range(0, 64));
      default: rand_sector = {16'($urandom()), 32'($urandom())};
    endcase
  endfunction

  function automatic logic [OFF_W-1:0] rand_offset();
    case ($urandom_range(0, 3))
      0:       rand_offset = '0;
      1:       rand_offset = OFF_W'(SECTOR_BYTES - 1);
      default: rand_offset = OFF_W'($urandom_range(0, SECTOR_BYTES - 1));
    endcase
  endfunction

  // Present one input word after a random gap and hold it until accepted
  task automatic send_word(dxc_op_e op, logic [ADDR_W-1:0] sec,
                           logic [OFF_W-1:0] off, logic [LEN_W-1:0] len);
    int unsigned gap;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (tight || pick < 40)  gap = 0;
    else if (pick < 85)      gap = $urandom_range(1, 3);
    else if (pick < 95)      gap = $urandom_range(4, 10);
    else                     gap = $urandom_range(20, 40);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    sector_i      <= sec;
    byte_offset_i <= off;
    byte_length_i <= len;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    extents.note_input(op, sec, off, len);
  endtask

  // Drop valid, wait for every predicted extent, then let the block settle
  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (extents.awaited.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_partition(logic [ADDR_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    extents.set_partition(value);
  endtask

  // Mostly runs that continue the pending one, plus broken runs and noise
  task automatic run_random(int unsigned count);
    int unsigned       kind;
    logic [ADDR_W-1:0] sec;
    logic [OFF_W-1:0]  off;
    logic [LEN_W-1:0]  len;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 50 == 0) tight = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 99);
      if (extents.run_count != 0) sec = extents.run_start + extents.run_count;
      else                        sec = rand_sector();
      if (kind < 45) begin
        len = LEN_W'($urandom_range(1, 8)) << SECTOR_BITS;
        if ($urandom_range(0, 4) == 0) len = len | LEN_W'($urandom_range(1, SECTOR_BYTES - 1));
        send_word(OP_READ, sec, '0, len);
      end else if (kind < 60) begin
        send_word(OP_READ, rand_sector(), '0, LEN_W'($urandom_range(1, 16)) << SECTOR_BITS);
      end else if (kind < 70) begin
        send_word(OP_FLUSH, rand_sector(), OFF_W'($urandom()), $urandom());
      end else if (kind < 88) begin
        send_word(OP_READ, rand_sector(), rand_offset(), LEN_W'($urandom_range(0, 3000)));
      end else if (kind < 93) begin
        send_word(OP_READ, rand_sector(), rand_offset(), $urandom());
      end else if ($urandom_range(0, 1) == 0) begin
        off = OFF_W'($urandom_range(1, SECTOR_BYTES - 1));
        send_word(OP_READ, sec, off, LEN_W'($urandom_range(0, 3000)));
      end else begin
        send_word(OP_READ, sec, '0, LEN_W'($urandom_range(0, SECTOR_BYTES - 1)));
      end
    end
    tight = 1'b0;
  endtask

  initial begin
    extents = new(SECTOR_BITS);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words with the partition start at its reset value
    send_word(OP_FLUSH, '0, '0, '0);
    send_word(OP_READ, 48'd100, '0, '0);
    send_word(OP_READ, 48'd100, '0, 2 * SECTOR_BYTES);
    send_word(OP_READ, 48'd102, '0, 3 * SECTOR_BYTES);
    send_word(OP_READ, 48'd105, '0, '0);
    send_word(OP_READ, 48'd900, '0, '0);
    send_word(OP_READ, 48'd105, '0, SECTOR_BYTES + 7);
    send_word(OP_READ, 48'd200, '0, 4 * SECTOR_BYTES);
    send_word(OP_READ, 48'd300, '0, SECTOR_BYTES);
    send_word(OP_FLUSH, '0, '0, '0);
    send_word(OP_READ, 48'd400, OFF_W'(SECTOR_BYTES - 1), 32'd1);
    send_word(OP_READ, 48'd401, 9'd5, '0);
    send_word(OP_READ, 48'd402, 9'd100, 32'd100);
    send_word(OP_READ, 48'd403, 9'd1, 32'hFFFF_FFFF);
    send_word(OP_READ, 48'd404 + 48'h7F_FFFF, '0, 32'hFFFF_FFFF);
    send_word(OP_READ, 48'd500, '0, SECTOR_BYTES);
    send_word(OP_READ, 48'd1000, 9'd10, 32'd1529);
    send_word(OP_READ, 48'hFFFF_FFFF_FFFF, '0, 2 * SECTOR_BYTES);
    send_word(OP_READ, 48'd1, '0, SECTOR_BYTES);
    send_word(OP_FLUSH, 48'hFFFF_FFFF_FFFF, 9'h1FF, 32'hFFFF_FFFF);
    send_word(OP_READ, 48'hFFFF_FFFF_FFFF, 9'd1, 32'd600);
    send_word(OP_READ, 48'd600, '0, 4 * SECTOR_BYTES);
    send_word(OP_READ, 48'd604, 9'd3, 32'd50);
    send_word(OP_READ, 48'd700, '0, SECTOR_BYTES);
    send_word(OP_READ, 48'd701, '0, 32'd100);
    send_word(OP_READ, 48'd800, '0, SECTOR_BYTES);

    // Random phases, each under its own partition start
    drain_and_settle();
    write_partition({ADDR_W{1'b1}});
    run_random(PHASE_WORDS);
    drain_and_settle();
    write_partition({16'($urandom()), 32'($urandom())});
    run_random(PHASE_WORDS);
    drain_and_settle();
    write_partition(48'd1);
    run_random(PHASE_WORDS);
    drain_and_settle();
    write_partition('0);
    run_random(PHASE_WORDS);
    drain_and_settle();
    write_partition(rand_sector());
    run_random(PHASE_WORDS);
    drain_and_settle();

    if (extents.mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
